>>> hw/rtl/gdad_pkg.sv
// Shared types, constants and the month-length table for the date adder.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package gdad_pkg;

    localparam int YEAR_W              = 14;
    localparam int MONTH_W             = 4;
    localparam int DAY_W               = 5;
    localparam int COUNT_W             = 20;
    localparam int STATUS_W            = 2;
    localparam int DAY_COUNT_WIDTH_DEF = 20;

    // Year reduction mod 400 runs one binary digit a cycle, 400 << 5 down to 400
    localparam int REDUCE_STEPS = 6;
    localparam int SHIFT_W      = $clog2(REDUCE_STEPS);

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  LEAP_CYCLE = YEAR_W'(400);
    localparam logic [YEAR_W-1:0]  CENTURY    = YEAR_W'(100);
    localparam logic [YEAR_W-1:0]  LEAP_EVERY = YEAR_W'(4);

    localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

    // Common-year month lengths; codes that name no month read as zero
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
    };

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic               load;
        logic               reduce;
        logic [SHIFT_W-1:0] shift;
        logic               check;
        logic               step;
    } gdad_cmd_t;

    typedef struct packed {
        logic date_bad;
        logic fits;
        logic year_ovf;
    } gdad_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/gdad_start_if.sv
// Request channel of the date adder: start date and day count.
// Depends on gdad_pkg for the field widths.
`default_nettype none

interface gdad_start_if;
    logic                         valid;
    logic                         ready;
    logic [gdad_pkg::YEAR_W-1:0]  start_year;
    logic [gdad_pkg::MONTH_W-1:0] start_month;
    logic [gdad_pkg::DAY_W-1:0]   start_day;
    logic [gdad_pkg::COUNT_W-1:0] days_to_add;

    modport source (output valid, start_year, start_month, start_day, days_to_add,
                    input ready);
    modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gdad_result_if.sv
// Result channel of the date adder: resulting date and status.
// Depends on gdad_pkg for the field widths.
`default_nettype none

interface gdad_result_if;
    logic                          valid;
    logic                          ready;
    logic [gdad_pkg::YEAR_W-1:0]   result_year;
    logic [gdad_pkg::MONTH_W-1:0]  result_month;
    logic [gdad_pkg::DAY_W-1:0]    result_day;
    logic [gdad_pkg::STATUS_W-1:0] status;

    modport source (output valid, result_year, result_month, result_day, status,
                    input ready);
    modport sink   (input valid, result_year, result_month, result_day, status,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gdad_datapath.sv
// Datapath of the date adder: date registers, year mod 400, month stepping.
// Depends on gdad_pkg; driven by gdad_ctrl through gdad_cmd_t.
`default_nettype none

module gdad_datapath #(
    parameter int DAY_COUNT_WIDTH = gdad_pkg::DAY_COUNT_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire gdad_pkg::gdad_cmd_t          cmd,
    output gdad_pkg::gdad_sts_t               sts,
    input  wire [gdad_pkg::YEAR_W-1:0]        start_year,
    input  wire [gdad_pkg::MONTH_W-1:0]       start_month,
    input  wire [gdad_pkg::DAY_W-1:0]         start_day,
    input  wire [gdad_pkg::COUNT_W-1:0]       days_to_add,
    output logic [gdad_pkg::YEAR_W-1:0]       result_year,
    output logic [gdad_pkg::MONTH_W-1:0]      result_month,
    output logic [gdad_pkg::DAY_W-1:0]        result_day,
    output logic [gdad_pkg::STATUS_W-1:0]     status
);
    import gdad_pkg::*;

    // Only the low DAY_COUNT_WIDTH bits of the count take part
    localparam int CNT_W = (DAY_COUNT_WIDTH < COUNT_W) ? DAY_COUNT_WIDTH : COUNT_W;
    localparam int ACC_W = CNT_W + 1;

    logic [YEAR_W-1:0]  year_reg;
    logic [YEAR_W-1:0]  ymod_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [ACC_W-1:0]   day_reg;
    logic [CNT_W-1:0]   cnt_reg;
    status_t            status_reg;

    logic               leap;
    logic [DAY_W-1:0]   month_days;
    logic [ACC_W-1:0]   month_days_ext;
    logic [YEAR_W-1:0]  reduce_sub;

    assign leap = ((year_reg % LEAP_EVERY) == '0) &&
                  (ymod_reg != CENTURY) &&
                  (ymod_reg != YEAR_W'(2 * CENTURY)) &&
                  (ymod_reg != YEAR_W'(3 * CENTURY));

    assign month_days     = MONTH_LEN[month_reg] + DAY_W'(month_reg == FEB && leap);
    assign month_days_ext = ACC_W'(month_days);
    assign reduce_sub     = LEAP_CYCLE << cmd.shift;

    assign sts.date_bad = (year_reg == '0) || (year_reg > YEAR_MAX) ||
                          (month_days == '0) || (day_reg == '0) ||
                          (day_reg > month_days_ext);
    assign sts.fits     = (day_reg <= month_days_ext);
    assign sts.year_ovf = !sts.fits && (month_reg == DEC) && (year_reg == YEAR_MAX);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            year_reg   <= start_year;
            ymod_reg   <= start_year;
            month_reg  <= start_month;
            day_reg    <= ACC_W'(start_day);
            cnt_reg    <= days_to_add[CNT_W-1:0];
            status_reg <= ST_OK;
        end
        else if (cmd.reduce)
        begin
            if (ymod_reg >= reduce_sub)
            begin
                ymod_reg <= ymod_reg - reduce_sub;
            end
        end
        else if (cmd.check)
        begin
            if (sts.date_bad)
            begin
                status_reg <= ST_INVALID;
            end
            day_reg <= day_reg + ACC_W'(cnt_reg);
        end
        else if (cmd.step && !sts.fits)
        begin
            day_reg <= day_reg - month_days_ext;
            if (month_reg == DEC)
            begin
                if (year_reg == YEAR_MAX)
                begin
                    status_reg <= ST_OVERFLOW;
                end
                else
                begin
                    month_reg <= JAN;
                    year_reg  <= year_reg + YEAR_W'(1);
                    ymod_reg  <= (ymod_reg == LEAP_CYCLE - YEAR_W'(1)) ?
                                 '0 : ymod_reg + YEAR_W'(1);
                end
            end
            else
            begin
                month_reg <= month_reg + MONTH_W'(1);
            end
        end
    end

    // Zero the date whenever the request ended in an error
    assign result_year  = (status_reg == ST_OK) ? year_reg : '0;
    assign result_month = (status_reg == ST_OK) ? month_reg : '0;
    assign result_day   = (status_reg == ST_OK) ? day_reg[DAY_W-1:0] : '0;
    assign status       = status_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gdad_ctrl.sv
// Controller of the date adder: sequences load, year reduction, check and stepping.
// Depends on gdad_pkg; commands gdad_datapath through gdad_cmd_t.
`default_nettype none

module gdad_ctrl (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      start_valid,
    output logic                     start_ready,
    output logic                     result_valid,
    input  wire                      result_ready,
    output gdad_pkg::gdad_cmd_t      cmd,
    input  wire gdad_pkg::gdad_sts_t sts
);
    import gdad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_STEP,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               start_ready_reg, start_ready_next;
    logic               result_valid_reg, result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        shift_next        = shift_reg;
        start_ready_next  = start_ready_reg;
        result_valid_next = result_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start_valid)
                begin
                    state_next       = S_REDUCE;
                    shift_next       = SHIFT_W'(REDUCE_STEPS - 1);
                    start_ready_next = 1'b0;
                end
            end
            S_REDUCE:
            begin
                if (shift_reg == '0)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    shift_next = shift_reg - SHIFT_W'(1);
                end
            end
            S_CHECK:
            begin
                if (sts.date_bad)
                begin
                    state_next        = S_DONE;
                    result_valid_next = 1'b1;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (sts.fits || sts.year_ovf)
                begin
                    state_next        = S_DONE;
                    result_valid_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (result_ready)
                begin
                    state_next        = S_IDLE;
                    result_valid_next = 1'b0;
                    start_ready_next  = 1'b1;
                end
            end
            default:
            begin
                state_next        = S_IDLE;
                result_valid_next = 1'b0;
                start_ready_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            shift_reg        <= '0;
            start_ready_reg  <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            shift_reg        <= shift_next;
            start_ready_reg  <= start_ready_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign start_ready  = start_ready_reg;
    assign result_valid = result_valid_reg;

    assign cmd.load   = (state_reg == S_IDLE) && start_valid;
    assign cmd.reduce = (state_reg == S_REDUCE);
    assign cmd.shift  = shift_reg;
    assign cmd.check  = (state_reg == S_CHECK);
    assign cmd.step   = (state_reg == S_STEP);

endmodule

`default_nettype wire

>>> hw/rtl/gregorian_date_add_days.sv
// Gregorian date adder: adds a day count to a start date, one request at a time.
// Depends on gdad_pkg, gdad_start_if, gdad_result_if, gdad_ctrl and gdad_datapath.
//
// A request is taken only while the block is idle; its result then waits on the
// result channel until taken, and the next request is accepted the cycle after.
// A request first reduces the year mod 400 for the leap rule, one binary digit
// at a time, then checks the start date and adds the count; the month-stepping
// loop then subtracts one month length per cycle until the day fits, so a full
// 20-bit count crosses up to about 34,500 months. An invalid start date returns
// with status 1 after the check; a year carried past 9999 stops with status 2.
// On either error the date fields read zero. Only the low DAY_COUNT_WIDTH bits
// of the count are used.
`default_nettype none

module gregorian_date_add_days #(
    parameter int DAY_COUNT_WIDTH = gdad_pkg::DAY_COUNT_WIDTH_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    gdad_start_if.sink    start,
    gdad_result_if.source result
);
    import gdad_pkg::*;

    gdad_cmd_t cmd;
    gdad_sts_t sts;

    gdad_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_valid  (start.valid),
        .start_ready  (start.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    gdad_datapath #(
        .DAY_COUNT_WIDTH (DAY_COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .sts          (sts),
        .start_year   (start.start_year),
        .start_month  (start.start_month),
        .start_day    (start.start_day),
        .days_to_add  (start.days_to_add),
        .result_year  (result.result_year),
        .result_month (result.result_month),
        .result_day   (result.result_day),
        .status       (result.status)
    );

endmodule

`default_nettype wire

>>> hw/rtl/gdad_checker.sv
// Port-level checks for the date adder, attached to the top level by bind.
// Depends on gdad_pkg and on the ports of gregorian_date_add_days.
`default_nettype none

module gdad_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            start_valid,
    input wire                            start_ready,
    input wire                            result_valid,
    input wire                            result_ready,
    input wire [gdad_pkg::YEAR_W-1:0]     result_year,
    input wire [gdad_pkg::MONTH_W-1:0]    result_month,
    input wire [gdad_pkg::DAY_W-1:0]      result_day,
    input wire [gdad_pkg::STATUS_W-1:0]   status
);
    import gdad_pkg::*;

    // One request in flight: no new request while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(start_ready && result_valid))
        else $error("request accepted while a result is pending");

    // An accepted request closes the request channel
    a_close_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start_valid && start_ready |=> !start_ready)
        else $error("request channel stayed open after accept");

    // Error results carry a zero date
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |->
            result_year == '0 && result_month == '0 && result_day == '0)
        else $error("error result with nonzero date");

    // Good results carry a date in range
    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OK |->
            result_year != '0 && result_year <= YEAR_MAX &&
            result_month != '0 && result_month <= DEC && result_day != '0)
        else $error("good result out of range");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_year) && $stable(result_month) &&
            $stable(result_day) && $stable(status))
        else $error("stalled result changed");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_valid  (start.valid),
    .start_ready  (start.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_year  (result.result_year),
    .result_month (result.result_month),
    .result_day   (result.result_day),
    .status       (result.status)
);

`default_nettype wire
